### rtl/core/tpo_pkg.sv
`timescale 1ns / 1ps
// tpo_pkg: widths, payload types and helpers of the triangle pair overlap test.
// Used by every file of the block but tpo_checker; depends on nothing.

package tpo_pkg;

   localparam int COORD_BITS = 16;
   // difference of two coordinates
   localparam int DIFF_BITS  = COORD_BITS + 1;
   // product of two differences
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   // difference of two products, exact
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int NUM_CROSS  = 14;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] x;
      logic signed [DIFF_BITS-1:0] y;
   } vec_type;

   // all edge vectors needed by the cross products, named by end and start point
   typedef struct packed {
      vec_type cp;
      vec_type bp;
      vec_type pq;
      vec_type bq;
      vec_type qc;
      vec_type bc;
      vec_type cq;
      vec_type qb;
      vec_type cb;
      vec_type pb;
      vec_type pc;
   } diff_set_type;

   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

   typedef sign_type [NUM_CROSS-1:0] sign_set_type;

   // load enables of the four pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } pipe_ctl_type;

   function automatic vec_type vsub(point_type a, point_type b);
      vec_type r;
      r.x = DIFF_BITS'(a.x) - DIFF_BITS'(b.x);
      r.y = DIFF_BITS'(a.y) - DIFF_BITS'(b.y);
      return r;
   endfunction

   // nonzero and equal signs
   function automatic logic same_side(sign_type a, sign_type b);
      return (a.pos && b.pos) || (a.neg && b.neg);
   endfunction

endpackage

### rtl/core/tpo_channels.sv
`timescale 1ns / 1ps
// tpo_req_if and tpo_rsp_if: valid/ready channels of the overlap test.
// Depends on tpo_pkg for the coordinate width.

interface tpo_req_if;
   logic valid;
   logic ready;
   logic signed [tpo_pkg::COORD_BITS-1:0] apex_b_x;
   logic signed [tpo_pkg::COORD_BITS-1:0] apex_b_y;
   logic signed [tpo_pkg::COORD_BITS-1:0] apex_c_x;
   logic signed [tpo_pkg::COORD_BITS-1:0] apex_c_y;
   logic signed [tpo_pkg::COORD_BITS-1:0] edge_p_x;
   logic signed [tpo_pkg::COORD_BITS-1:0] edge_p_y;
   logic signed [tpo_pkg::COORD_BITS-1:0] edge_q_x;
   logic signed [tpo_pkg::COORD_BITS-1:0] edge_q_y;

   modport source (
      output valid, apex_b_x, apex_b_y, apex_c_x, apex_c_y,
             edge_p_x, edge_p_y, edge_q_x, edge_q_y,
      input  ready
   );
   modport sink (
      input  valid, apex_b_x, apex_b_y, apex_c_x, apex_c_y,
             edge_p_x, edge_p_y, edge_q_x, edge_q_y,
      output ready
   );
endinterface

interface tpo_rsp_if;
   logic valid;
   logic ready;
   logic overlap;

   modport source (output valid, overlap, input ready);
   modport sink (input valid, overlap, output ready);
endinterface

### rtl/core/tpo_diff.sv
`timescale 1ns / 1ps
// tpo_diff: first pipeline stage, forms and registers the edge vectors.
// Depends on tpo_pkg.

module tpo_diff (
   input  logic                  clock,
   input  tpo_pkg::pipe_ctl_type ctl,
   input  tpo_pkg::point_type    pt_b,
   input  tpo_pkg::point_type    pt_c,
   input  tpo_pkg::point_type    pt_p,
   input  tpo_pkg::point_type    pt_q,
   output tpo_pkg::diff_set_type diff_ff
);

   tpo_pkg::diff_set_type diff_in;

   always_comb begin
      diff_in.cp = tpo_pkg::vsub(pt_c, pt_p);
      diff_in.bp = tpo_pkg::vsub(pt_b, pt_p);
      diff_in.pq = tpo_pkg::vsub(pt_p, pt_q);
      diff_in.bq = tpo_pkg::vsub(pt_b, pt_q);
      diff_in.qc = tpo_pkg::vsub(pt_q, pt_c);
      diff_in.bc = tpo_pkg::vsub(pt_b, pt_c);
      diff_in.cq = tpo_pkg::vsub(pt_c, pt_q);
      diff_in.qb = tpo_pkg::vsub(pt_q, pt_b);
      diff_in.cb = tpo_pkg::vsub(pt_c, pt_b);
      diff_in.pb = tpo_pkg::vsub(pt_p, pt_b);
      diff_in.pc = tpo_pkg::vsub(pt_p, pt_c);
   end

   always_ff @(posedge clock) begin
      if (ctl.s1) begin
         diff_ff <= diff_in;
      end
   end

endmodule

### rtl/core/tpo_cross.sv
`timescale 1ns / 1ps
// tpo_cross: sign of the 2d cross product u.x*v.y - u.y*v.x, exact.
// Two stages: products, then difference and sign. Depends on tpo_pkg.

module tpo_cross (
   input  logic                  clock,
   input  logic                  reset,
   input  tpo_pkg::pipe_ctl_type ctl,
   input  tpo_pkg::vec_type      u,
   input  tpo_pkg::vec_type      v,
   output tpo_pkg::sign_type     sign_ff
);

   localparam int PW = tpo_pkg::PROD_BITS;
   localparam int CW = tpo_pkg::CROSS_BITS;

   logic signed [PW-1:0] prod_p_in;
   logic signed [PW-1:0] prod_q_in;
   logic signed [PW-1:0] prod_p_ff;
   logic signed [PW-1:0] prod_q_ff;
   logic signed [CW-1:0] cross_diff;
   tpo_pkg::sign_type    sign_in;

   assign prod_p_in = PW'(u.x) * PW'(v.y);
   assign prod_q_in = PW'(u.y) * PW'(v.x);

   always_comb begin
      cross_diff  = CW'(prod_p_ff) - CW'(prod_q_ff);
      sign_in.neg = cross_diff[CW-1];
      sign_in.pos = !cross_diff[CW-1] && (|cross_diff);
   end

   always_ff @(posedge clock) begin
      if (ctl.s2) begin
         prod_p_ff <= prod_p_in;
         prod_q_ff <= prod_q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_ff <= '0;
      end else if (ctl.s3) begin
         sign_ff <= sign_in;
      end
   end

endmodule

### rtl/core/tpo_decide.sv
`timescale 1ns / 1ps
// tpo_decide: last stage, combines the cross product signs into the overlap flag.
// Depends on tpo_pkg.

module tpo_decide (
   input  logic                  clock,
   input  tpo_pkg::pipe_ctl_type ctl,
   input  tpo_pkg::sign_set_type signs,
   output logic                  overlap_ff
);

   logic inside_b;
   logic inside_c;
   logic cross_pb_qc;
   logic cross_qb_pc;
   logic overlap_in;

   always_comb begin
      // apex strictly inside the other triangle: all three signs agree and are nonzero
      inside_b = tpo_pkg::same_side(signs[0], signs[1]) &&
                 tpo_pkg::same_side(signs[1], signs[2]) &&
                 tpo_pkg::same_side(signs[2], signs[0]);
      inside_c = tpo_pkg::same_side(signs[3], signs[4]) &&
                 tpo_pkg::same_side(signs[4], signs[5]) &&
                 tpo_pkg::same_side(signs[5], signs[3]);
      // segments cross unless one lies wholly on one side of the other
      cross_pb_qc = !(tpo_pkg::same_side(signs[6], signs[7]) ||
                      tpo_pkg::same_side(signs[8], signs[9]));
      cross_qb_pc = !(tpo_pkg::same_side(signs[10], signs[11]) ||
                      tpo_pkg::same_side(signs[12], signs[13]));
      overlap_in = inside_b || inside_c || cross_pb_qc || cross_qb_pc;
   end

   always_ff @(posedge clock) begin
      if (ctl.s4) begin
         overlap_ff <= overlap_in;
      end
   end

endmodule

### rtl/core/triangle_pair_overlap_test.sv
`timescale 1ns / 1ps
// triangle_pair_overlap_test: top level, four-stage pipeline with valid tracking.
// Depends on tpo_pkg, tpo_channels, tpo_diff, tpo_cross and tpo_decide.

// Takes one pair of triangles sharing edge P-Q per clock and answers overlap one
// transaction per cycle when the sink keeps rsp_if.ready high. The result shows on
// rsp_if once the item has passed four register stages in order: edge
// vectors, 14 pairs of 17 x 17 bit products, exact difference and sign, then the
// overlap decision.
// Each stage holds its item only while the stage after it is full and stalled, so a
// bubble anywhere is filled and req_if.ready drops only when all four stages are full
// and the result is not taken. Touching and collinear segments count as overlap; an apex
// on a border line is not inside.

module triangle_pair_overlap_test (
   input  logic      clock,
   input  logic      reset,
   tpo_req_if.sink   req_if,
   tpo_rsp_if.source rsp_if
);

   tpo_pkg::pipe_ctl_type ctl;
   logic [3:0]            valid_ff;
   logic [3:0]            valid_in;
   tpo_pkg::point_type    pt_b;
   tpo_pkg::point_type    pt_c;
   tpo_pkg::point_type    pt_p;
   tpo_pkg::point_type    pt_q;
   tpo_pkg::diff_set_type diff;
   tpo_pkg::vec_type      cross_u [tpo_pkg::NUM_CROSS];
   tpo_pkg::vec_type      cross_v [tpo_pkg::NUM_CROSS];
   tpo_pkg::sign_set_type signs;
   logic                  overlap;

   // a stage loads when it is empty or the stage after it moves on
   always_comb begin
      ctl.s4 = !valid_ff[3] || rsp_if.ready;
      ctl.s3 = !valid_ff[2] || ctl.s4;
      ctl.s2 = !valid_ff[1] || ctl.s3;
      ctl.s1 = !valid_ff[0] || ctl.s2;
      valid_in[0] = ctl.s1 ? req_if.valid : valid_ff[0];
      valid_in[1] = ctl.s2 ? valid_ff[0]  : valid_ff[1];
      valid_in[2] = ctl.s3 ? valid_ff[1]  : valid_ff[2];
      valid_in[3] = ctl.s4 ? valid_ff[2]  : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_if.ready   = ctl.s1;
   assign rsp_if.valid   = valid_ff[3];
   assign rsp_if.overlap = overlap;

   assign pt_b = '{x: req_if.apex_b_x, y: req_if.apex_b_y};
   assign pt_c = '{x: req_if.apex_c_x, y: req_if.apex_c_y};
   assign pt_p = '{x: req_if.edge_p_x, y: req_if.edge_p_y};
   assign pt_q = '{x: req_if.edge_q_x, y: req_if.edge_q_y};

   tpo_diff u_diff (
      .clock   (clock),
      .ctl     (ctl),
      .pt_b    (pt_b),
      .pt_c    (pt_c),
      .pt_p    (pt_p),
      .pt_q    (pt_q),
      .diff_ff (diff)
   );

   always_comb begin
      // b inside c-p-q
      cross_u[0]  = diff.cp;  cross_v[0]  = diff.bp;
      cross_u[1]  = diff.pq;  cross_v[1]  = diff.bq;
      cross_u[2]  = diff.qc;  cross_v[2]  = diff.bc;
      // c inside b-p-q
      cross_u[3]  = diff.bp;  cross_v[3]  = diff.cp;
      cross_u[4]  = diff.pq;  cross_v[4]  = diff.cq;
      cross_u[5]  = diff.qb;  cross_v[5]  = diff.cb;
      // segment p-b against q-c
      cross_u[6]  = diff.pb;  cross_v[6]  = diff.qb;
      cross_u[7]  = diff.pb;  cross_v[7]  = diff.cb;
      cross_u[8]  = diff.qc;  cross_v[8]  = diff.pc;
      cross_u[9]  = diff.qc;  cross_v[9]  = diff.bc;
      // segment q-b against p-c
      cross_u[10] = diff.qb;  cross_v[10] = diff.pb;
      cross_u[11] = diff.qb;  cross_v[11] = diff.cb;
      cross_u[12] = diff.pc;  cross_v[12] = diff.qc;
      cross_u[13] = diff.pc;  cross_v[13] = diff.bc;
   end

   for (genvar i = 0; i < tpo_pkg::NUM_CROSS; i++) begin : g_cross
      tpo_cross u_cross (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .u       (cross_u[i]),
         .v       (cross_v[i]),
         .sign_ff (signs[i])
      );
   end

   tpo_decide u_decide (
      .clock      (clock),
      .ctl        (ctl),
      .signs      (signs),
      .overlap_ff (overlap)
   );

endmodule

### rtl/core/tpo_checker.sv
`timescale 1ns / 1ps
// tpo_checker: port-level assertions for triangle_pair_overlap_test, and its bind.
// Depends on triangle_pair_overlap_test and its channel interfaces.

module tpo_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_overlap
);

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   // a result waiting is held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_overlap))
      else $error("result transaction dropped or changed while stalled");

   // input backpressure only when the whole pipeline is blocked by the sink
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the result side is free");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result transaction right after reset");

   // with no input accepted and the sink ready while the pipeline empties, no result is left
   assert property (@(posedge clock) disable iff (reset)
      !$past(req_acc, 1) && !$past(req_acc, 2) && !$past(req_acc, 3) &&
      !$past(req_acc, 4) && $past(rsp_ready, 1) && $past(rsp_ready, 2) &&
      $past(rsp_ready, 3) && $past(rsp_ready, 4) |-> !rsp_valid)
      else $error("result transaction without a matching input transaction");

endmodule

bind triangle_pair_overlap_test tpo_checker u_tpo_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_overlap (rsp_if.overlap)
);
